// ===== sv/ray_cast_range_finder_assert.svh =====
//------------------------------------------------------------------------------
// Ray cast range finder assertion macros
// Shared macros for the concurrent checks on the range finder ports.
//------------------------------------------------------------------------------
`ifndef RAY_CAST_RANGE_FINDER_ASSERT_SVH
`define RAY_CAST_RANGE_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCRF_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("range finder check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCRF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("range finder check failed");

`endif

// ===== sv/rcrf_pkg.sv =====
//------------------------------------------------------------------------------
// Range finder package
// Types, constants and tables shared by the range finder modules.
//------------------------------------------------------------------------------
package rcrf_pkg;

	localparam int SEG_DEPTH    = 64;
	localparam int CIR_DEPTH    = 64;
	localparam int SEG_AW       = 6;
	localparam int CIR_AW       = 6;
	localparam int COUNT_W      = 7;
	localparam int DIST_W       = 15;
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = 17;
	localparam int DIR_W        = 18;
	localparam int ACC_W        = 48;
	localparam int MUL_W        = 22;
	localparam int NUM_MAG_W    = 38;
	localparam int RAD_W        = 40;
	localparam int ROOT_W       = 20;
	localparam int QUOT_W       = 16;
	localparam int CORDIC_STEPS = 14;
	localparam int CORDIC_GAIN  = 9949;
	localparam int DIST_RESET   = 2560;
	localparam int SEG_STEPS    = 8;
	localparam int CIR_STEPS    = 6;
	localparam int ADDR_W       = 4;

	typedef enum logic [1:0] {
		OP_SEG   = 2'd0,
		OP_CIR   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_SEG_COUNT = 2'd0,
		REG_CIR_COUNT = 2'd1,
		REG_MAX_DIST  = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		opcode_t                     opcode;
		logic [5:0]                  entry_index;
		logic signed [COORD_W-1:0]   a_x;
		logic signed [COORD_W-1:0]   a_y;
		logic signed [COORD_W-1:0]   b_x;
		logic signed [COORD_W-1:0]   b_y;
		logic [DIST_W-1:0]           circle_radius;
		logic signed [COORD_W-1:0]   query_x;
		logic signed [COORD_W-1:0]   query_y;
		logic [15:0]                 query_heading;
	} cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] range;
		logic              hit;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} seg_entry_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [DIST_W-1:0]         r;
	} cir_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIR,
		ST_SEG_RD,
		ST_SEG_LD,
		ST_SEG_MUL,
		ST_SEG_CHK,
		ST_SEG_DIV,
		ST_CIR_RD,
		ST_CIR_LD,
		ST_CIR_MUL,
		ST_CIR_CHK,
		ST_CIR_SQRT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef struct packed {
		logic      valid;
		logic [1:0] dst;
		acc_mode_t mode;
	} mul_op_t;

	typedef enum logic {
		DS_DIV,
		DS_SQRT
	} ds_mode_t;

	typedef struct packed {
		logic     start;
		ds_mode_t mode;
	} ds_ctrl_t;

	function automatic logic [13:0] atan_entry(input logic [3:0] i);
		logic [13:0] v;
		case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/rcrf_ram.sv =====
//------------------------------------------------------------------------------
// Range finder RAM
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
module rcrf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rcrf_cordic.sv =====
//------------------------------------------------------------------------------
// Range finder direction unit
// Iterative CORDIC that turns a binary angle into a Q1.14 unit vector.
//------------------------------------------------------------------------------
module rcrf_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [15:0]                      heading,
	output logic                             done,
	output logic signed [rcrf_pkg::DIR_W-1:0] dir_c,
	output logic signed [rcrf_pkg::DIR_W-1:0] dir_s
);
	import rcrf_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic                    flip_q;
	logic [3:0]              iter_q;
	logic signed [DIR_W-1:0] x_q;
	logic signed [DIR_W-1:0] y_q;
	logic signed [DIR_W-1:0] z_q;
	logic signed [DIR_W-1:0] c_q;
	logic signed [DIR_W-1:0] s_q;
	logic signed [DIR_W-1:0] z_init;
	logic                    flip_init;
	logic signed [DIR_W-1:0] dx;
	logic signed [DIR_W-1:0] dy;
	logic signed [DIR_W-1:0] x_n;
	logic signed [DIR_W-1:0] y_n;
	logic signed [DIR_W-1:0] z_n;
	logic signed [DIR_W-1:0] step_angle;

	always_comb begin
		z_init    = $signed({2'b00, heading});
		flip_init = 1'b0;
		if (heading >= 16'd16384 && heading < 16'd49152) begin
			z_init    = $signed({2'b00, heading}) - DIR_W'(32768);
			flip_init = 1'b1;
		end else if (heading >= 16'd49152) begin
			z_init = $signed({2'b00, heading}) - DIR_W'(65536);
		end
	end

	always_comb begin
		step_angle = $signed({4'b0000, atan_entry(iter_q)});
		dx = y_q >>> iter_q;
		dy = x_q >>> iter_q;
		if (!z_q[DIR_W-1]) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - step_angle;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + step_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 4'd1;
				if (iter_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= DIR_W'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (iter_q == 4'(CORDIC_STEPS - 1)) begin
				c_q <= flip_q ? -x_n : x_n;
				s_q <= flip_q ? -y_n : y_n;
			end
		end
	end

	assign done  = done_q;
	assign dir_c = c_q;
	assign dir_s = s_q;

endmodule

// ===== sv/rcrf_divsqrt.sv =====
//------------------------------------------------------------------------------
// Range finder divide and root unit
// Restoring shift and subtract unit for the segment distance quotient and the
// circle integer square root, one bit per cycle.
//------------------------------------------------------------------------------
module rcrf_divsqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcrf_pkg::ds_ctrl_t                  ctrl,
	input  logic [rcrf_pkg::NUM_MAG_W-1:0]      num_mag,
	input  logic [rcrf_pkg::NUM_MAG_W-1:0]      den_mag,
	input  logic [rcrf_pkg::RAD_W-1:0]          radicand,
	output logic                                done,
	output logic [rcrf_pkg::QUOT_W-1:0]         quot,
	output logic [rcrf_pkg::ROOT_W-1:0]         root
);
	import rcrf_pkg::*;

	localparam int REM_W = NUM_MAG_W + QUOT_W;

	logic              busy_q;
	logic              done_q;
	ds_mode_t          mode_q;
	logic [4:0]        cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] q_q;
	logic [RAD_W-1:0]  n_q;
	logic [RAD_W-1:0]  res_q;
	logic [RAD_W-1:0]  bit_q;
	logic [RAD_W-1:0]  trial;
	logic              last;

	assign trial = res_q + bit_q;
	assign last  = (mode_q == DS_DIV) ? (cnt_q == 5'(QUOT_W - 1)) : (cnt_q == 5'(ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.mode;
			rem_q  <= REM_W'({num_mag, 14'b0});
			dsh_q  <= REM_W'({den_mag, 15'b0});
			q_q    <= '0;
			n_q    <= radicand;
			res_q  <= '0;
			bit_q  <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (mode_q == DS_DIV) begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					q_q   <= {q_q[QUOT_W-2:0], 1'b1};
				end else begin
					q_q <= {q_q[QUOT_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end else begin
				if (n_q >= trial) begin
					n_q   <= n_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

// ===== sv/ray_cast_range_finder.sv =====
//------------------------------------------------------------------------------
// Ray cast range finder
// Simulated range sensor over stored line segments and circles.
//------------------------------------------------------------------------------
// Items arrive on the cmd channel (valid/ready). A segment or circle write is
// stored when accepted and gives no result. A query computes the heading
// vector with a 14-step CORDIC, then walks the first min(segment_count, 64)
// segments and the first min(circle_count, 64) circles through one shared
// multiplier and one shift/subtract unit. A segment uses the divider only
// when its hit check passes; a circle uses the square root only when its
// discriminant is not negative. cmd_ready is low while a query runs. The
// result goes to an output register on the res channel; while it waits, the
// next item is accepted, and a finished query holds until the register is
// free. Reset clears the control state and the registers to their reset
// values; the stores are undefined until written. The APB port writes
// segment_count, circle_count and max_dist at 0x0, 0x4 and 0x8.
//------------------------------------------------------------------------------
module ray_cast_range_finder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  rcrf_pkg::cmd_t                  cmd,
	output logic                            res_valid,
	input  logic                            res_ready,
	output rcrf_pkg::res_t                  res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rcrf_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import rcrf_pkg::*;

	state_t                    state_q;
	state_t                    state_d;
	logic [COUNT_W-1:0]        seg_count_q;
	logic [COUNT_W-1:0]        cir_count_q;
	logic [DIST_W-1:0]         max_dist_q;
	logic [COUNT_W-1:0]        seg_lim;
	logic [COUNT_W-1:0]        cir_lim;
	logic [COUNT_W-1:0]        idx_q;
	logic [3:0]                step_q;
	logic [DIST_W-1:0]         best_q;
	logic signed [COORD_W-1:0] qx_q;
	logic signed [COORD_W-1:0] qy_q;
	logic signed [DIFF_W-1:0]  ax_q;
	logic signed [DIFF_W-1:0]  ay_q;
	logic signed [DIFF_W-1:0]  bx_q;
	logic signed [DIFF_W-1:0]  by_q;
	logic signed [DIFF_W-1:0]  ex_q;
	logic signed [DIFF_W-1:0]  ey_q;
	logic [DIST_W-1:0]         r_q;
	logic signed [ACC_W-1:0]   acc_q [4];
	logic signed [ACC_W-1:0]   prod_s1;
	mul_op_t                   op_s1;
	mul_op_t                   op_issue;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	res_t                      res_q;
	logic                      res_valid_q;
	logic                      cmd_accept;
	logic                      cfg_write;
	logic                      seg_re;
	logic                      cir_re;
	logic                      dir_start;
	logic                      dir_done;
	logic signed [DIR_W-1:0]   dir_c;
	logic signed [DIR_W-1:0]   dir_s;
	ds_ctrl_t                  ds_ctrl;
	logic                      ds_done;
	logic [QUOT_W-1:0]         ds_quot;
	logic [ROOT_W-1:0]         ds_root;
	seg_entry_t                seg_rd;
	seg_entry_t                seg_wr;
	cir_entry_t                cir_rd;
	cir_entry_t                cir_wr;
	logic                      seg_miss;
	logic signed [ACC_W-1:0]   num_abs;
	logic signed [ACC_W-1:0]   den_abs;
	logic signed [MUL_W-1:0]   n8;
	logic signed [MUL_W:0]     cir_dist;
	logic                      res_load;

	assign cmd_accept = cmd_valid && cmd_ready;
	assign cfg_write  = psel && penable && pwrite;
	assign pready     = 1'b1;
	assign seg_lim    = (seg_count_q > COUNT_W'(SEG_DEPTH)) ? COUNT_W'(SEG_DEPTH) : seg_count_q;
	assign cir_lim    = (cir_count_q > COUNT_W'(CIR_DEPTH)) ? COUNT_W'(CIR_DEPTH) : cir_count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= '0;
			cir_count_q <= '0;
			max_dist_q  <= DIST_W'(DIST_RESET);
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_SEG_COUNT: seg_count_q <= pwdata[COUNT_W-1:0];
				REG_CIR_COUNT: cir_count_q <= pwdata[COUNT_W-1:0];
				REG_MAX_DIST:  max_dist_q  <= pwdata[DIST_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_SEG_COUNT: prdata = 32'(seg_count_q);
			REG_CIR_COUNT: prdata = 32'(cir_count_q);
			REG_MAX_DIST:  prdata = 32'(max_dist_q);
			default:       prdata = '0;
		endcase
	end

	// Shape stores.
	assign seg_wr = '{ax: cmd.a_x, ay: cmd.a_y, bx: cmd.b_x, by: cmd.b_y};
	assign cir_wr = '{cx: cmd.a_x, cy: cmd.a_y, r: cmd.circle_radius};

	rcrf_ram #(
		.WIDTH($bits(seg_entry_t)),
		.DEPTH(SEG_DEPTH)
	) u_seg_ram (
		.clk  (clk),
		.we   (cmd_accept && cmd.opcode == OP_SEG),
		.waddr(cmd.entry_index[SEG_AW-1:0]),
		.wdata(seg_wr),
		.re   (seg_re),
		.raddr(idx_q[SEG_AW-1:0]),
		.rdata(seg_rd)
	);

	rcrf_ram #(
		.WIDTH($bits(cir_entry_t)),
		.DEPTH(CIR_DEPTH)
	) u_cir_ram (
		.clk  (clk),
		.we   (cmd_accept && cmd.opcode == OP_CIR),
		.waddr(cmd.entry_index[CIR_AW-1:0]),
		.wdata(cir_wr),
		.re   (cir_re),
		.raddr(idx_q[CIR_AW-1:0]),
		.rdata(cir_rd)
	);

	rcrf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dir_start),
		.heading(cmd.query_heading),
		.done   (dir_done),
		.dir_c  (dir_c),
		.dir_s  (dir_s)
	);

	assign num_abs  = acc_q[0][ACC_W-1] ? -acc_q[0] : acc_q[0];
	assign den_abs  = acc_q[1][ACC_W-1] ? -acc_q[1] : acc_q[1];
	assign n8       = $signed(acc_q[0][MUL_W+13:14]);
	assign cir_dist = (MUL_W+1)'(n8) - $signed((MUL_W+1)'(ds_root));

	rcrf_divsqrt u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ds_ctrl),
		.num_mag (num_abs[NUM_MAG_W-1:0]),
		.den_mag (den_abs[NUM_MAG_W-1:0]),
		.radicand(acc_q[1][RAD_W-1:0]),
		.done    (ds_done),
		.quot    (ds_quot),
		.root    (ds_root)
	);

	assign seg_miss = (acc_q[1] == '0) || (acc_q[0] == '0)
		|| ((acc_q[0] > 0) != (acc_q[1] > 0))
		|| ((acc_q[2] > 0) && (acc_q[3] > 0))
		|| ((acc_q[2] < 0) && (acc_q[3] < 0));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (cmd_accept && cmd.opcode == OP_QUERY) state_d = ST_DIR;
			ST_DIR:      if (dir_done) state_d = ST_SEG_RD;
			ST_SEG_RD:   state_d = (idx_q == seg_lim) ? ST_CIR_RD : ST_SEG_LD;
			ST_SEG_LD:   state_d = ST_SEG_MUL;
			ST_SEG_MUL:  if (step_q == 4'(SEG_STEPS)) state_d = ST_SEG_CHK;
			ST_SEG_CHK:  state_d = seg_miss ? ST_SEG_RD : ST_SEG_DIV;
			ST_SEG_DIV:  if (ds_done) state_d = ST_SEG_RD;
			ST_CIR_RD:   state_d = (idx_q == cir_lim) ? ST_DONE : ST_CIR_LD;
			ST_CIR_LD:   state_d = ST_CIR_MUL;
			ST_CIR_MUL:  if (step_q == 4'(CIR_STEPS)) state_d = ST_CIR_CHK;
			ST_CIR_CHK:  state_d = acc_q[1][ACC_W-1] ? ST_CIR_RD : ST_CIR_SQRT;
			ST_CIR_SQRT: if (ds_done) state_d = ST_CIR_RD;
			ST_DONE:     if (!res_valid_q || res_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		cmd_ready    = (state_q == ST_IDLE);
		dir_start    = cmd_valid && (state_q == ST_IDLE) && cmd.opcode == OP_QUERY;
		seg_re       = (state_q == ST_SEG_RD);
		cir_re       = (state_q == ST_CIR_RD);
		ds_ctrl.start = 1'b0;
		ds_ctrl.mode  = DS_DIV;
		res_load     = 1'b0;
		case (state_q)
			ST_SEG_CHK: ds_ctrl.start = !seg_miss;
			ST_CIR_CHK: begin
				ds_ctrl.start = !acc_q[1][ACC_W-1];
				ds_ctrl.mode  = DS_SQRT;
			end
			ST_DONE:    res_load = !res_valid_q || res_ready;
			default:    ;
		endcase
	end

	// Multiplier schedule.
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		op_issue = '{valid: 1'b0, dst: 2'd0, mode: ACC_LOAD};
		if (state_q == ST_SEG_MUL && step_q < 4'(SEG_STEPS)) begin
			op_issue.valid = 1'b1;
			case (step_q)
				4'd0: begin mul_a = MUL_W'(ey_q); mul_b = MUL_W'(ax_q); op_issue.dst = 2'd0; end
				4'd1: begin
					mul_a = MUL_W'(ex_q); mul_b = MUL_W'(ay_q);
					op_issue.dst = 2'd0; op_issue.mode = ACC_SUB;
				end
				4'd2: begin mul_a = MUL_W'(dir_c); mul_b = MUL_W'(ey_q); op_issue.dst = 2'd1; end
				4'd3: begin
					mul_a = MUL_W'(dir_s); mul_b = MUL_W'(ex_q);
					op_issue.dst = 2'd1; op_issue.mode = ACC_SUB;
				end
				4'd4: begin mul_a = MUL_W'(dir_c); mul_b = MUL_W'(ay_q); op_issue.dst = 2'd2; end
				4'd5: begin
					mul_a = MUL_W'(dir_s); mul_b = MUL_W'(ax_q);
					op_issue.dst = 2'd2; op_issue.mode = ACC_SUB;
				end
				4'd6: begin mul_a = MUL_W'(dir_c); mul_b = MUL_W'(by_q); op_issue.dst = 2'd3; end
				default: begin
					mul_a = MUL_W'(dir_s); mul_b = MUL_W'(bx_q);
					op_issue.dst = 2'd3; op_issue.mode = ACC_SUB;
				end
			endcase
		end else if (state_q == ST_CIR_MUL && step_q < 4'(CIR_STEPS)) begin
			op_issue.valid = 1'b1;
			case (step_q)
				4'd0: begin mul_a = MUL_W'(dir_c); mul_b = MUL_W'(ax_q); op_issue.dst = 2'd0; end
				4'd1: begin
					mul_a = MUL_W'(dir_s); mul_b = MUL_W'(ay_q);
					op_issue.dst = 2'd0; op_issue.mode = ACC_ADD;
				end
				4'd2: begin
					mul_a = $signed(MUL_W'(r_q)); mul_b = $signed(MUL_W'(r_q));
					op_issue.dst = 2'd1;
				end
				4'd3: begin
					mul_a = MUL_W'(ax_q); mul_b = MUL_W'(ax_q);
					op_issue.dst = 2'd1; op_issue.mode = ACC_SUB;
				end
				4'd4: begin
					mul_a = MUL_W'(ay_q); mul_b = MUL_W'(ay_q);
					op_issue.dst = 2'd1; op_issue.mode = ACC_SUB;
				end
				default: begin
					mul_a = n8; mul_b = n8;
					op_issue.dst = 2'd1; op_issue.mode = ACC_ADD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			op_s1       <= '{valid: 1'b0, dst: 2'd0, mode: ACC_LOAD};
		end else begin
			state_q <= state_d;
			op_s1   <= op_issue;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ACC_W'(mul_a * mul_b);
		if (op_s1.valid) begin
			case (op_s1.mode)
				ACC_LOAD: acc_q[op_s1.dst] <= prod_s1;
				ACC_ADD:  acc_q[op_s1.dst] <= acc_q[op_s1.dst] + prod_s1;
				ACC_SUB:  acc_q[op_s1.dst] <= acc_q[op_s1.dst] - prod_s1;
				default:  ;
			endcase
		end
		if (res_load) begin
			res_q <= '{range: best_q, hit: best_q < max_dist_q};
		end
		case (state_q)
			ST_IDLE: begin
				qx_q   <= cmd.query_x;
				qy_q   <= cmd.query_y;
				best_q <= max_dist_q;
				idx_q  <= '0;
			end
			ST_SEG_RD: if (idx_q == seg_lim) idx_q <= '0;
			ST_SEG_LD: begin
				ax_q   <= DIFF_W'(seg_rd.ax) - DIFF_W'(qx_q);
				ay_q   <= DIFF_W'(seg_rd.ay) - DIFF_W'(qy_q);
				bx_q   <= DIFF_W'(seg_rd.bx) - DIFF_W'(qx_q);
				by_q   <= DIFF_W'(seg_rd.by) - DIFF_W'(qy_q);
				ex_q   <= DIFF_W'(seg_rd.bx) - DIFF_W'(seg_rd.ax);
				ey_q   <= DIFF_W'(seg_rd.by) - DIFF_W'(seg_rd.ay);
				step_q <= '0;
			end
			ST_SEG_MUL, ST_CIR_MUL: step_q <= step_q + 4'd1;
			ST_SEG_CHK: if (seg_miss) idx_q <= idx_q + COUNT_W'(1);
			ST_SEG_DIV: begin
				if (ds_done) begin
					idx_q <= idx_q + COUNT_W'(1);
					if (!ds_quot[QUOT_W-1] && ds_quot[DIST_W-1:0] < best_q) begin
						best_q <= ds_quot[DIST_W-1:0];
					end
				end
			end
			ST_CIR_LD: begin
				ax_q   <= DIFF_W'(cir_rd.cx) - DIFF_W'(qx_q);
				ay_q   <= DIFF_W'(cir_rd.cy) - DIFF_W'(qy_q);
				r_q    <= cir_rd.r;
				step_q <= '0;
			end
			ST_CIR_CHK: if (acc_q[1][ACC_W-1]) idx_q <= idx_q + COUNT_W'(1);
			ST_CIR_SQRT: begin
				if (ds_done) begin
					idx_q <= idx_q + COUNT_W'(1);
					if (!cir_dist[MUL_W] && cir_dist < $signed((MUL_W+1)'(best_q))) begin
						best_q <= cir_dist[DIST_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/rcrf_checker.sv =====
//------------------------------------------------------------------------------
// Range finder port checker
// Concurrent checks on the range finder ports, bound to the top level.
//------------------------------------------------------------------------------
`include "ray_cast_range_finder_assert.svh"

module rcrf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input rcrf_pkg::cmd_t              cmd,
	input logic                        res_valid,
	input logic                        res_ready,
	input rcrf_pkg::res_t              res
);
	import rcrf_pkg::*;

	`RCRF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	`RCRF_ASSERT_NEXT(a_write_no_res, cmd_valid && cmd_ready && cmd.opcode != OP_QUERY, !$rose(res_valid))
	`RCRF_ASSERT_NEXT(a_query_busy, cmd_valid && cmd_ready && cmd.opcode == OP_QUERY, !cmd_ready)
	`RCRF_ASSERT_SAME(a_hit_below_max, res_valid && res.hit, res.range != 15'h7fff)

endmodule

bind ray_cast_range_finder rcrf_checker u_rcrf_checker (.*);
